FILE: hdl/mtg_pkg.sv
package mtg_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // term slots: determinant, three tangent numerators, three bitangent numerators
    localparam logic [2:0] TERM_DET  = 3'd0;
    localparam logic [2:0] TERM_TAN  = 3'd1;
    localparam logic [2:0] TERM_BIT  = 3'd4;
    localparam logic [2:0] TERM_LAST = 3'd6;
    localparam logic [2:0] ADD_LAST  = 3'd5;

    localparam logic [1:0] CNT_LAST = 2'd2;

    localparam logic DIV_QUOT = 1'b0;
    localparam logic DIV_NORM = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       clr_wr;
        logic       load_wr;
        logic       g_rd;
        logic       g_cap;
        logic       a_rd_tri;
        logic       a_rd_vi;
        logic       a_wr;
        logic       mul_en;
        logic       mul_second;
        logic       mul_sq;
        logic       hold_ld;
        logic       diff_wr;
        logic       set_flag;
        logic       div_start;
        logic       div_mode;
        logic       div_wr;
        logic       n_load;
        logic       n_shift;
        logic       sum_add;
        logic       sum_clr;
        logic       sq_start;
        logic       n_zero;
        logic       out_clr;
        logic       vec;
        logic [1:0] cnt;
        logic [2:0] term;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       vi_ok;
        logic       tri_ok;
        logic       det_zero;
        logic       div_done;
        logic       sqrt_done;
        logic       m_big;
        logic       sum_zero;
        logic       clr_last;
    } t_sts;

endpackage

FILE: hdl/mesh_tangent_generation.sv
// Tangent and bitangent generation for an indexed mesh. A request is taken when
// start is high and busy is low; o_valid then marks a read's result for exactly
// one cycle and cannot be held off, so the receiver must take it as it comes.
// A triangle spends nearly all its time in the shared divider that produces one
// quotient bit per cycle for six quotients. A read of nonzero vectors takes, per
// vector, up to 18 normalizing shift steps, 31 square-root steps and three
// divisions. After reset the block clears the accumulator store, one vertex per
// cycle, all min(MAX_VERTICES, 1024) entries, with busy high; configuration
// writes are taken throughout.
module mesh_tangent_generation #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [9:0]         i_vertex_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_tex_u,
    input  logic signed [31:0] i_tex_v,
    input  logic [9:0]         i_corner_a,
    input  logic [9:0]         i_corner_b,
    input  logic [9:0]         i_corner_c,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic signed [15:0] o_tangent_x,
    output logic signed [15:0] o_tangent_y,
    output logic signed [15:0] o_tangent_z,
    output logic signed [15:0] o_bitangent_x,
    output logic signed [15:0] o_bitangent_y,
    output logic signed [15:0] o_bitangent_z,
    output logic               o_degenerate_seen
);
    import mtg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mtg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    mtg_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_operation       (i_operation),
        .i_vertex_index    (i_vertex_index),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_tex_u           (i_tex_u),
        .i_tex_v           (i_tex_v),
        .i_corner_a        (i_corner_a),
        .i_corner_b        (i_corner_b),
        .i_corner_c        (i_corner_c),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_tangent_x       (o_tangent_x),
        .o_tangent_y       (o_tangent_y),
        .o_tangent_z       (o_tangent_z),
        .o_bitangent_x     (o_bitangent_x),
        .o_bitangent_y     (o_bitangent_y),
        .o_bitangent_z     (o_bitangent_z),
        .o_degenerate_seen (o_degenerate_seen)
    );
endmodule

FILE: hdl/mtg_div.sv
module mtg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic        r_run;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_lo;
    logic [63:0] r_q;
    logic [63:0] r_den;
    logic [64:0] rem2;
    logic [64:0] diff;
    logic        ge;

    assign rem2 = {r_rem, r_lo[63]};
    assign diff = rem2 - {1'b0, r_den};
    assign ge   = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_hi;
            r_lo  <= i_lo;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_run) begin
            r_rem <= ge ? diff[63:0] : rem2[63:0];
            r_lo  <= {r_lo[62:0], 1'b0};
            r_q   <= {r_q[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

FILE: hdl/mtg_sqrt.sv
module mtg_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [61:0] i_op,
    output logic        o_done,
    output logic [30:0] o_root
);
    logic        r_run;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [61:0] r_rem;
    logic [61:0] r_res;
    logic [61:0] r_bit;
    logic [61:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // two radicand bits per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_op;
            r_res <= '0;
            r_bit <= 62'd1 << 60;
        end else if (r_run) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[30:0];
endmodule

FILE: hdl/mtg_dp.sv
module mtg_dp #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtg_pkg::t_cmd       i_cmd,
    output mtg_pkg::t_sts       o_sts,
    input  logic [1:0]          i_operation,
    input  logic [9:0]          i_vertex_index,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic signed [31:0]  i_tex_u,
    input  logic signed [31:0]  i_tex_v,
    input  logic [9:0]          i_corner_a,
    input  logic [9:0]          i_corner_b,
    input  logic [9:0]          i_corner_c,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_wdata,
    output logic signed [15:0]  o_tangent_x,
    output logic signed [15:0]  o_tangent_y,
    output logic signed [15:0]  o_tangent_z,
    output logic signed [15:0]  o_bitangent_x,
    output logic signed [15:0]  o_bitangent_y,
    output logic signed [15:0]  o_bitangent_z,
    output logic                o_degenerate_seen
);
    import mtg_pkg::*;

    localparam int DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [63:0] ACC_MAX = 64'h0000_7FFF_FFFF_FFFF;

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return d[31:0];
    endfunction

    function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                     input logic signed [47:0] b);
        logic signed [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) return s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        return s[47:0];
    endfunction

    logic [10:0]         r_vcount;
    logic                r_flag;
    logic [1:0]          r_op;
    logic [9:0]          r_vi;
    logic [159:0]        r_geo;
    logic [9:0]          r_c [3];
    logic [AW-1:0]       r_clr;

    logic [159:0]        g_mem [DEPTH];
    logic [159:0]        r_g_rd;
    logic [287:0]        a_mem [DEPTH];
    logic [287:0]        r_a_rd;

    logic [159:0]        r_p0;
    logic signed [31:0]  r_e1 [3];
    logic signed [31:0]  r_e2 [3];
    logic signed [31:0]  r_du1, r_dv1, r_du2, r_dv2;
    logic signed [63:0]  r_prod;
    logic signed [63:0]  r_hold;
    logic signed [63:0]  r_num [7];
    logic signed [47:0]  r_add [6];
    logic [47:0]         r_m [3];
    logic                r_neg [3];
    logic [61:0]         r_sum;
    logic [15:0]         r_out [6];

    logic                vi_ok, tri_ok;
    logic [AW-1:0]       vi_addr, c_addr;
    logic [9:0]          c_sel;
    logic                a_we, a_re;
    logic [AW-1:0]       a_waddr, a_raddr;
    logic [287:0]        a_wdata, acc_sum;
    logic signed [31:0]  g_w [5];
    logic signed [31:0]  p_w [5];
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic [1:0]          ti;
    logic signed [63:0]  q_num, q_det;
    logic [63:0]         q_n, d_mag, q_hi, q_lo, q_mag, n_lo, quo;
    logic                q_sat, q_neg;
    logic [47:0]         q48;
    logic [15:0]         q16;
    logic [2:0]          o_idx;
    logic [143:0]        half;
    logic                div_done, sqrt_done;
    logic [30:0]         root;
    logic [63:0]         div_hi, div_lo, div_den;

    assign vi_ok  = (int'(r_vi) < int'(r_vcount)) && (int'(r_vi) < MAX_VERTICES);
    assign tri_ok = (int'(r_c[0]) < int'(r_vcount)) && (int'(r_c[0]) < MAX_VERTICES)
                 && (int'(r_c[1]) < int'(r_vcount)) && (int'(r_c[1]) < MAX_VERTICES)
                 && (int'(r_c[2]) < int'(r_vcount)) && (int'(r_c[2]) < MAX_VERTICES);
    assign vi_addr = r_vi[AW-1:0];
    assign c_sel   = r_c[i_cmd.cnt];
    assign c_addr  = c_sel[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_flag   <= 1'b0;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) r_vcount <= i_cfg_wdata;
            if (i_cmd.set_flag) r_flag <= 1'b1;
            if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_operation;
            r_vi   <= i_vertex_index;
            r_geo  <= {i_tex_v, i_tex_u, i_pos_z, i_pos_y, i_pos_x};
            r_c[0] <= i_corner_a;
            r_c[1] <= i_corner_b;
            r_c[2] <= i_corner_c;
        end
    end

    // accumulator store
    always_comb begin
        for (int w = 0; w < 6; w++) begin
            acc_sum[48*w +: 48] = sat_add48(r_a_rd[48*w +: 48], r_add[w]);
        end
    end

    assign a_we    = i_cmd.clr_wr || (i_cmd.load_wr && vi_ok) || i_cmd.a_wr;
    assign a_waddr = i_cmd.clr_wr ? r_clr : (i_cmd.load_wr ? vi_addr : c_addr);
    assign a_wdata = i_cmd.a_wr ? acc_sum : '0;
    assign a_re    = i_cmd.a_rd_tri || i_cmd.a_rd_vi;
    assign a_raddr = i_cmd.a_rd_vi ? vi_addr : c_addr;

    always_ff @(posedge i_clk) begin
        if (a_we) a_mem[a_waddr] <= a_wdata;
        if (a_re) r_a_rd <= a_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && vi_ok) g_mem[vi_addr] <= r_geo;
        if (i_cmd.g_rd) r_g_rd <= g_mem[c_addr];
    end

    // edge and UV deltas
    always_comb begin
        for (int w = 0; w < 5; w++) begin
            g_w[w] = r_g_rd[32*w +: 32];
            p_w[w] = r_p0[32*w +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.g_cap) begin
            case (i_cmd.cnt)
                2'd0: r_p0 <= r_g_rd;
                2'd1: begin
                    for (int i = 0; i < 3; i++) r_e1[i] <= sat_sub(g_w[i], p_w[i]);
                    r_du1 <= sat_sub(g_w[3], p_w[3]);
                    r_dv1 <= sat_sub(g_w[4], p_w[4]);
                end
                default: begin
                    for (int i = 0; i < 3; i++) r_e2[i] <= sat_sub(g_w[i], p_w[i]);
                    r_du2 <= sat_sub(g_w[3], p_w[3]);
                    r_dv2 <= sat_sub(g_w[4], p_w[4]);
                end
            endcase
        end
    end

    // shared multiplier: products of the terms, then squares for the norm
    always_comb begin
        ti    = 2'd0;
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_sq) begin
            mul_a = {2'b00, r_m[i_cmd.cnt][29:0]};
            mul_b = {2'b00, r_m[i_cmd.cnt][29:0]};
        end else begin
            case (i_cmd.term) inside
                TERM_DET: begin
                    mul_a = i_cmd.mul_second ? r_dv1 : r_du1;
                    mul_b = i_cmd.mul_second ? r_du2 : r_dv2;
                end
                [TERM_TAN:TERM_BIT-3'd1]: begin
                    ti    = 2'(i_cmd.term - TERM_TAN);
                    mul_a = i_cmd.mul_second ? r_dv1 : r_dv2;
                    mul_b = i_cmd.mul_second ? r_e2[ti] : r_e1[ti];
                end
                default: begin
                    ti    = 2'(i_cmd.term - TERM_BIT);
                    mul_a = i_cmd.mul_second ? r_du2 : r_du1;
                    mul_b = i_cmd.mul_second ? r_e1[ti] : r_e2[ti];
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= mul_p;
        if (i_cmd.hold_ld) r_hold <= r_prod;
        if (i_cmd.diff_wr) r_num[i_cmd.term] <= r_hold - r_prod;
    end

    // divider operands
    assign q_num  = r_num[i_cmd.term + 3'd1];
    assign q_det  = r_num[TERM_DET];
    assign q_n    = q_num[63] ? -q_num : q_num;
    assign d_mag  = q_det[63] ? -q_det : q_det;
    assign q_hi   = {48'd0, q_n[63:48]};
    assign q_lo   = {q_n[47:0], 16'd0};
    assign q_sat  = q_hi >= d_mag;
    assign q_neg  = q_num[63] ^ q_det[63];
    assign n_lo   = {20'd0, r_m[i_cmd.cnt][29:0], 14'd0} + {34'd0, root[30:1]};

    assign div_hi  = (i_cmd.div_mode == DIV_NORM) ? 64'd0 : q_hi;
    assign div_lo  = (i_cmd.div_mode == DIV_NORM) ? n_lo : q_lo;
    assign div_den = (i_cmd.div_mode == DIV_NORM) ? {33'd0, root} : d_mag;

    mtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    mtg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_op    (r_sum),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    assign q_mag = (q_sat || quo > ACC_MAX) ? ACC_MAX : quo;
    assign q48   = q_mag[47:0];
    assign q16   = quo[15:0];
    assign o_idx = i_cmd.vec ? 3'(i_cmd.cnt) + 3'd3 : 3'(i_cmd.cnt);
    assign half  = i_cmd.vec ? r_a_rd[287:144] : r_a_rd[143:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_wr) begin
            if (i_cmd.div_mode == DIV_NORM) begin
                r_out[o_idx] <= r_neg[i_cmd.cnt] ? -q16 : q16;
            end else begin
                r_add[i_cmd.term] <= q_neg ? -q48 : q48;
            end
        end
        if (i_cmd.n_load) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= half[48*i+47];
                r_m[i]   <= half[48*i+47] ? -half[48*i +: 48] : half[48*i +: 48];
            end
        end else if (i_cmd.n_shift) begin
            for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
        end
        if (i_cmd.sum_add) r_sum <= (i_cmd.sum_clr ? 62'd0 : r_sum) + r_prod[61:0];
        if (i_cmd.out_clr) begin
            for (int i = 0; i < 6; i++) r_out[i] <= '0;
        end else if (i_cmd.n_zero) begin
            for (int i = 0; i < 3; i++) r_out[3'((i_cmd.vec ? 3 : 0) + i)] <= '0;
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.vi_ok     = vi_ok;
        o_sts.tri_ok    = tri_ok;
        o_sts.det_zero  = (r_num[TERM_DET] == 64'sd0);
        o_sts.div_done  = div_done;
        o_sts.sqrt_done = sqrt_done;
        o_sts.m_big     = (|r_m[0][47:30]) || (|r_m[1][47:30]) || (|r_m[2][47:30]);
        o_sts.sum_zero  = (r_sum == 62'd0);
        o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
    end

    assign o_tangent_x       = r_out[0];
    assign o_tangent_y       = r_out[1];
    assign o_tangent_z       = r_out[2];
    assign o_bitangent_x     = r_out[3];
    assign o_bitangent_y     = r_out[4];
    assign o_bitangent_z     = r_out[5];
    assign o_degenerate_seen = r_flag;
endmodule

FILE: hdl/mtg_ctrl.sv
module mtg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_valid,
    output mtg_pkg::t_cmd o_cmd,
    input  mtg_pkg::t_sts i_sts
);
    import mtg_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_GRD   = 5'd3;
    localparam logic [4:0] S_GCAP  = 5'd4;
    localparam logic [4:0] S_MUL0  = 5'd5;
    localparam logic [4:0] S_MUL1  = 5'd6;
    localparam logic [4:0] S_DIFF  = 5'd7;
    localparam logic [4:0] S_DETCK = 5'd8;
    localparam logic [4:0] S_DIVS  = 5'd9;
    localparam logic [4:0] S_DIVW  = 5'd10;
    localparam logic [4:0] S_ARD   = 5'd11;
    localparam logic [4:0] S_AWR   = 5'd12;
    localparam logic [4:0] S_RRD   = 5'd13;
    localparam logic [4:0] S_NLD   = 5'd14;
    localparam logic [4:0] S_NSH   = 5'd15;
    localparam logic [4:0] S_SQ    = 5'd16;
    localparam logic [4:0] S_SQA   = 5'd17;
    localparam logic [4:0] S_SQCK  = 5'd18;
    localparam logic [4:0] S_SQW   = 5'd19;
    localparam logic [4:0] S_NDS   = 5'd20;
    localparam logic [4:0] S_NDW   = 5'd21;
    localparam logic [4:0] S_OUT   = 5'd22;

    logic [4:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic [2:0] r_term, n_term;
    logic       r_vec, n_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_term  <= '0;
            r_vec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_term  <= n_term;
            r_vec   <= n_vec;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_term     = r_term;
        n_vec      = r_vec;
        o_cmd      = '0;
        o_cmd.cnt  = r_cnt;
        o_cmd.term = r_term;
        o_cmd.vec  = r_vec;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                n_cnt  = '0;
                n_term = '0;
                n_vec  = 1'b0;
                case (i_sts.op)
                    OP_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        n_state       = S_IDLE;
                    end
                    OP_TRI: n_state = i_sts.tri_ok ? S_GRD : S_IDLE;
                    OP_READ: begin
                        if (i_sts.vi_ok) begin
                            n_state = S_RRD;
                        end else begin
                            o_cmd.out_clr = 1'b1;
                            n_state       = S_OUT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_GRD: begin
                o_cmd.g_rd = 1'b1;
                n_state    = S_GCAP;
            end
            S_GCAP: begin
                o_cmd.g_cap = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MUL0;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = S_GRD;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_second = 1'b1;
                o_cmd.hold_ld    = 1'b1;
                n_state          = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff_wr = 1'b1;
                if (r_term == TERM_LAST) begin
                    n_term  = '0;
                    n_state = S_DETCK;
                end else begin
                    n_term  = r_term + 3'd1;
                    n_state = S_MUL0;
                end
            end
            S_DETCK: begin
                if (i_sts.det_zero) begin
                    o_cmd.set_flag = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_DIVS;
                end
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_mode  = DIV_QUOT;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                o_cmd.div_mode = DIV_QUOT;
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    if (r_term == ADD_LAST) begin
                        n_cnt   = '0;
                        n_state = S_ARD;
                    end else begin
                        n_term  = r_term + 3'd1;
                        n_state = S_DIVS;
                    end
                end
            end
            S_ARD: begin
                o_cmd.a_rd_tri = 1'b1;
                n_state        = S_AWR;
            end
            S_AWR: begin
                // write back before the next corner reads, so repeated corners add twice
                o_cmd.a_wr = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = S_ARD;
                end
            end
            S_RRD: begin
                o_cmd.a_rd_vi = 1'b1;
                n_state       = S_NLD;
            end
            S_NLD: begin
                o_cmd.n_load = 1'b1;
                n_state      = S_NSH;
            end
            S_NSH: begin
                if (i_sts.m_big) begin
                    o_cmd.n_shift = 1'b1;
                end else begin
                    n_cnt   = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sq = 1'b1;
                n_state      = S_SQA;
            end
            S_SQA: begin
                o_cmd.sum_add = 1'b1;
                o_cmd.sum_clr = (r_cnt == 2'd0);
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_SQCK;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = S_SQ;
                end
            end
            S_SQCK: begin
                if (i_sts.sum_zero) begin
                    o_cmd.n_zero = 1'b1;
                    if (r_vec) begin
                        n_state = S_OUT;
                    end else begin
                        n_vec   = 1'b1;
                        n_state = S_NLD;
                    end
                end else begin
                    o_cmd.sq_start = 1'b1;
                    n_state        = S_SQW;
                end
            end
            S_SQW: begin
                if (i_sts.sqrt_done) begin
                    n_cnt   = '0;
                    n_state = S_NDS;
                end
            end
            S_NDS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_mode  = DIV_NORM;
                n_state         = S_NDW;
            end
            S_NDW: begin
                o_cmd.div_mode = DIV_NORM;
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    if (r_cnt != CNT_LAST) begin
                        n_cnt   = r_cnt + 2'd1;
                        n_state = S_NDS;
                    end else if (r_vec) begin
                        n_state = S_OUT;
                    end else begin
                        n_vec   = 1'b1;
                        n_state = S_NLD;
                    end
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule

FILE: tb/sv/mesh_tangent_generation_checker.sv
module mesh_tangent_generation_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [9:0]         i_vertex_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_tex_u,
    input  logic signed [31:0] i_tex_v,
    input  logic [9:0]         i_corner_a,
    input  logic [9:0]         i_corner_b,
    input  logic [9:0]         i_corner_c,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_wdata,
    input  logic               o_valid,
    input  logic signed [15:0] o_tangent_x,
    input  logic signed [15:0] o_tangent_y,
    input  logic signed [15:0] o_tangent_z,
    input  logic signed [15:0] o_bitangent_x,
    input  logic signed [15:0] o_bitangent_y,
    input  logic signed [15:0] o_bitangent_z,
    input  logic               o_degenerate_seen,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_compared,
    output int                 o_degenerates
);
    import mtg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SLOTS   = 1024;
    localparam longint ACC_TOP = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_BOT = -ACC_TOP - 1;

    typedef struct packed {
        logic [5:0][15:0] comp;
        logic             flag;
    } t_frame;

    longint     geom [SLOTS][5];
    longint     acc  [SLOTS][6];
    logic       degen_flag;
    logic [10:0] vcount;
    t_frame     frame_q [$];

    function automatic longint sat_delta(longint a, longint b);
        longint d;
        d = a - b;
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        return d;
    endfunction

    // (num << 16) / det toward zero, magnitude clamped to the accumulator top
    function automatic longint scaled_div(longint num, longint det);
        logic [63:0]  nm, dm;
        logic [127:0] q;
        logic         neg;
        nm  = num < 0 ? -num : num;
        dm  = det < 0 ? -det : det;
        neg = (num < 0) != (det < 0);
        q   = ({64'd0, nm} << 16) / {64'd0, dm};
        if (q > 128'(ACC_TOP)) q = 128'(ACC_TOP);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint sat_acc(longint a, longint b);
        longint s;
        s = a + b;
        if (s > ACC_TOP) s = ACC_TOP;
        if (s < ACC_BOT) s = ACC_BOT;
        return s;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] op);
        logic [63:0] res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > op) b >>= 2;
        while (b != 0) begin
            if (op >= res + b) begin
                op  = op - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [2:0][15:0] unit_q14(longint a, longint b, longint c);
        longint           v [3];
        logic [63:0]      m [3];
        logic [63:0]      big, sum, r, q;
        logic [2:0][15:0] res;
        int               sh;
        v = '{a, b, c};
        big = 0;
        sum = 0;
        sh  = 0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > big) big = m[i];
        end
        while ((big >> sh) >= (64'd1 << 30)) sh++;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> sh;
            sum += m[i] * m[i];
        end
        if (sum == 0) return res;
        r = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 14) + (r >> 1)) / r;
            res[i] = v[i] < 0 ? 16'(-q) : q[15:0];
        end
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    task automatic tangent_predict();
        int      lim;
        int      c [3];
        longint  e1 [3], e2 [3], add [6];
        longint  du1, dv1, du2, dv2, det;
        t_frame  f;
        lim = vcount < SLOTS ? vcount : SLOTS;
        case (i_operation)
            OP_LOAD: begin
                if (i_vertex_index < lim) begin
                    geom[i_vertex_index] = '{i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v};
                    foreach (acc[i_vertex_index][k]) acc[i_vertex_index][k] = 0;
                end
            end
            OP_TRI: begin
                c = '{i_corner_a, i_corner_b, i_corner_c};
                if (c[0] < lim && c[1] < lim && c[2] < lim) begin
                    for (int i = 0; i < 3; i++) begin
                        e1[i] = sat_delta(geom[c[1]][i], geom[c[0]][i]);
                        e2[i] = sat_delta(geom[c[2]][i], geom[c[0]][i]);
                    end
                    du1 = sat_delta(geom[c[1]][3], geom[c[0]][3]);
                    dv1 = sat_delta(geom[c[1]][4], geom[c[0]][4]);
                    du2 = sat_delta(geom[c[2]][3], geom[c[0]][3]);
                    dv2 = sat_delta(geom[c[2]][4], geom[c[0]][4]);
                    det = du1 * dv2 - dv1 * du2;
                    if (det == 0) begin
                        degen_flag = 1'b1;
                        o_degenerates++;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            add[i]     = scaled_div(dv2 * e1[i] - dv1 * e2[i], det);
                            add[3 + i] = scaled_div(du1 * e2[i] - du2 * e1[i], det);
                        end
                        // repeated corners each take their own addition
                        for (int k = 0; k < 3; k++)
                            for (int i = 0; i < 6; i++)
                                acc[c[k]][i] = sat_acc(acc[c[k]][i], add[i]);
                    end
                end
            end
            OP_READ: begin
                f = '0;
                if (i_vertex_index < lim) begin
                    f.comp[2:0] = unit_q14(acc[i_vertex_index][0], acc[i_vertex_index][1],
                                           acc[i_vertex_index][2]);
                    f.comp[5:3] = unit_q14(acc[i_vertex_index][3], acc[i_vertex_index][4],
                                           acc[i_vertex_index][5]);
                end
                f.flag = degen_flag;
                frame_q.insert(frame_q.size(), f);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_frame want;
        logic [5:0][15:0] got;
        if (!i_rst_n) begin
            foreach (acc[v, k]) acc[v][k] = 0;
            degen_flag = 1'b0;
            vcount     = '0;
            frame_q.delete();
        end else begin
            if (i_cfg_we) vcount = i_cfg_wdata;
            if (start && !busy) tangent_predict();
            if (o_valid) begin
                got = {o_bitangent_z, o_bitangent_y, o_bitangent_x,
                       o_tangent_z, o_tangent_y, o_tangent_x};
                if (frame_q.size() == 0) begin
                    report("result with no request waiting", 1, 0);
                end else begin
                    want = frame_q.pop_front();
                    o_compared++;
                    for (int i = 0; i < 6; i++)
                        if (got[i] !== want.comp[i])
                            report($sformatf("%s_%s", i < 3 ? "tangent" : "bitangent",
                                   i % 3 == 0 ? "x" : i % 3 == 1 ? "y" : "z"),
                                   $signed(got[i]), $signed(want.comp[i]));
                    if (o_degenerate_seen !== want.flag)
                        report("degenerate_seen", o_degenerate_seen, want.flag);
                end
            end
        end
        o_pending = frame_q.size();
    end

endmodule

FILE: tb/sv/mesh_tangent_generation_tb.sv
module mesh_tangent_generation_tb;
    import mtg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         SLOTS     = 1024;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_operation;
    logic [9:0]         i_vertex_index;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v;
    logic [9:0]         i_corner_a, i_corner_b, i_corner_c;
    logic               i_cfg_we;
    logic [10:0]        i_cfg_wdata;
    logic               o_valid;
    logic signed [15:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic signed [15:0] o_bitangent_x, o_bitangent_y, o_bitangent_z;
    logic               o_degenerate_seen;
    int                 errors, pending, compared, degenerates;

    logic       loaded [SLOTS];
    int         limit;
    int         gap_pct;
    int         n_load, n_tri, n_read, n_phase;
    int         settings [6] = '{3, 1024, 0, 17, 1000, 1024};

    mesh_tangent_generation #(.MAX_VERTICES(SLOTS)) DUT (.*);

    mesh_tangent_generation_checker checker_i (
        .*,
        .o_errors(errors),
        .o_pending(pending),
        .o_compared(compared),
        .o_degenerates(degenerates)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // hold start high across back-to-back requests; drop it only for gaps
    task automatic issue(input logic [1:0] op, input logic [9:0] vi,
                         input logic [31:0] px, py, pz, tu, tv,
                         input logic [9:0] ca, cb, cc);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_operation    <= op;
        i_vertex_index <= vi;
        i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_tex_u <= tu; i_tex_v <= tv;
        i_corner_a <= ca; i_corner_b <= cb; i_corner_c <= cc;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        case (op)
            OP_LOAD: begin
                n_load++;
                if (vi < limit) loaded[vi] = 1'b1;
            end
            OP_TRI:  n_tri++;
            OP_READ: n_read++;
            default: ;
        endcase
    endtask

    task automatic load_vertex(input logic [9:0] vi, input logic [31:0] px, py, pz, tu, tv);
        issue(OP_LOAD, vi, px, py, pz, tu, tv, '0, '0, '0);
    endtask

    task automatic triangle(input logic [9:0] ca, cb, cc);
        issue(OP_TRI, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, ca, cb, cc);
    endtask

    task automatic read_vertex(input logic [9:0] vi);
        issue(OP_READ, vi, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
    endtask

    // write vertex_count only once the block is idle and nothing is owed
    task automatic set_vertex_count(input int cnt);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 11'(cnt);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit = cnt < SLOTS ? cnt : SLOTS;
        n_phase++;
    endtask

    function automatic logic [31:0] coord();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($urandom_range(0, 1048576) - 524288);
    endfunction

    function automatic logic [9:0] pick_slot();
        if (limit > 0 && $urandom_range(0, 4) != 0)
            return 10'($urandom_range(0, (limit < 16 ? limit : 16) - 1));
        return 10'($urandom_range(0, SLOTS - 1));
    endfunction

    function automatic int pick_loaded();
        int pool [$];
        for (int i = 0; i < limit && i < 16; i++) if (loaded[i]) pool.insert(pool.size(), i);
        if (pool.size() == 0) return -1;
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    task automatic random_request();
        int roll, a, b, c;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            load_vertex(pick_slot(), coord(), coord(), coord(), coord(), coord());
        end else if (roll < 70) begin
            a = pick_loaded();
            b = pick_loaded();
            c = pick_loaded();
            if ($urandom_range(0, 9) == 0) b = a;  // repeated corner forces zero det
            if (limit < SLOTS && (a < 0 || $urandom_range(0, 6) == 0)) begin
                // one corner beyond the limit skips the whole triangle
                a = $urandom_range(limit, SLOTS - 1);
                if (b < 0) b = $urandom_range(limit, SLOTS - 1);
                if (c < 0) c = $urandom_range(limit, SLOTS - 1);
                case ($urandom_range(0, 2))
                    0: triangle(10'(a), 10'(b), 10'(c));
                    1: triangle(10'(b), 10'(a), 10'(c));
                    default: triangle(10'(b), 10'(c), 10'(a));
                endcase
            end else if (a >= 0) begin
                triangle(10'(a), 10'(b), 10'(c));
            end else begin
                load_vertex(pick_slot(), coord(), coord(), coord(), coord(), coord());
            end
        end else if (roll < 95) begin
            read_vertex(pick_slot());
        end else begin
            issue(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int waited;
        start = 1'b0;
        i_operation = OP_LOAD;
        i_vertex_index = '0;
        {i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v} = '0;
        {i_corner_a, i_corner_b, i_corner_c} = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        gap_pct = 0;
        limit = 0;
        {n_load, n_tri, n_read, n_phase} = '0;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_vertex_count(1024);
        // right-angle triangle with unit UVs
        load_vertex(0, 0, 0, 0, 0, 0);
        load_vertex(1, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
        load_vertex(2, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
        read_vertex(5);                       // untouched vertex reads as zero
        triangle(0, 1, 2);
        read_vertex(0);
        read_vertex(1);
        // field extremes, saturating deltas
        load_vertex(1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000);
        load_vertex(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF);
        load_vertex(4, 32'hFFFF_FFFF, 0, 32'h0000_0001, 0, 0);
        triangle(1023, 3, 4);
        read_vertex(1023);
        read_vertex(3);
        // tiny determinant against large edges drives the quotient clamp
        load_vertex(5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
        load_vertex(6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0);
        load_vertex(7, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
        triangle(5, 6, 7);
        triangle(5, 6, 7);
        read_vertex(6);
        triangle(0, 0, 0);                    // zero determinant sets the sticky flag
        triangle(2, 1, 1);
        read_vertex(2);
        issue(OP_UNUSED, 10'h3FF, '1, '1, '1, '1, '1, '1, '1, '1);
        read_vertex(7);

        foreach (settings[p]) begin
            set_vertex_count(settings[p]);
            for (int n = 0; n < 72; n++) begin
                // alternate gappy and gap-free stretches
                case ((p + n / 24) % 3)
                    0: gap_pct = 0;
                    1: gap_pct = 84;
                    default: gap_pct = 29;
                endcase
                random_request();
            end
        end

        start <= 1'b0;
        gap_pct = 0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while ((pending != 0 || busy) && waited < 5000);
        repeat (600) @(posedge i_clk);
        $display("covered %0d loads, %0d triangles (%0d degenerate), %0d reads over %0d counts",
                 n_load, n_tri, degenerates, n_read, n_phase);
        $display("compared %0d read results, %0d left waiting", compared, pending);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
